[hw/rtl/sbse_pkg.sv]
// ----------------------------------------------------------------------------
// Stack bytecode step engine package
// Shared types, opcodes, status codes and defaults for the engine.
// ----------------------------------------------------------------------------
package sbse_pkg;

    localparam int PROGRAM_DEPTH_DEF = 1024;
    localparam int STACK_DEPTH_DEF   = 256;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [1:0] CFG_ENTRY_POINT    = 2'd0;
    localparam logic [1:0] CFG_PROGRAM_LENGTH = 2'd1;
    localparam logic [1:0] CFG_STEP_LIMIT     = 2'd2;

    localparam logic [9:0]  ENTRY_POINT_RST    = 10'd0;
    localparam logic [10:0] PROGRAM_LENGTH_RST = 11'd1;
    localparam logic [31:0] STEP_LIMIT_RST     = 32'd1000000;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_PUSH_INT = 8'h01;
    localparam logic [7:0] OP_POP      = 8'h04;
    localparam logic [7:0] OP_DUP      = 8'h05;
    localparam logic [7:0] OP_ADD      = 8'h10;
    localparam logic [7:0] OP_SUB      = 8'h11;
    localparam logic [7:0] OP_MUL      = 8'h12;
    localparam logic [7:0] OP_DIV      = 8'h13;
    localparam logic [7:0] OP_JUMP     = 8'h20;
    localparam logic [7:0] OP_JZ       = 8'h21;
    localparam logic [7:0] OP_NATIVE   = 8'h30;
    localparam logic [7:0] OP_HALT     = 8'hFF;

    localparam logic [3:0] ST_RUN     = 4'd0;
    localparam logic [3:0] ST_HALT    = 4'd1;
    localparam logic [3:0] ST_OVER    = 4'd2;
    localparam logic [3:0] ST_UNDER   = 4'd3;
    localparam logic [3:0] ST_DIVZ    = 4'd4;
    localparam logic [3:0] ST_BADJ    = 4'd5;
    localparam logic [3:0] ST_PCOUT   = 4'd6;
    localparam logic [3:0] ST_ILLEGAL = 4'd7;
    localparam logic [3:0] ST_LIMIT   = 4'd8;
    localparam logic [3:0] ST_NATIVE  = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RELOAD,
        S_RELOAD2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         prog_address;
        logic [7:0]         opcode;
        logic signed [31:0] immediate;
        logic [31:0]        jump_target;
    } t_in;

    typedef struct packed {
        logic [3:0]         status;
        logic [31:0]        pc_value;
        logic signed [31:0] top_value;
        logic [8:0]         stack_depth;
        logic [31:0]        steps_done;
    } t_out;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] immediate;
        logic [31:0] target;
    } t_word;

endpackage

[hw/rtl/sbse_div.sv]
// ----------------------------------------------------------------------------
// Signed 32-bit divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sbse_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic        r_neg, n_neg;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 32'd0;
            n_quo  = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            n_dvs  = i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            n_neg  = i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                n_rem = w_diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

[hw/rtl/stack_bytecode_step_engine_unit.sv]
// ----------------------------------------------------------------------------
// Stack bytecode step engine
// A 32-bit integer stack machine that loads, resets and single-steps programs.
// ----------------------------------------------------------------------------
// Each request produces one result. Write, reset, unknown-command and frozen or
// rejected step requests go straight to the result state; an executed instruction
// passes through the registered program and stack memory reads and then the
// write-back in the execute state. DIV waits in its own state while the divider
// retires one quotient bit per cycle, and a divide by zero that leaves values on
// the stack passes through S_RELOAD and S_RELOAD2 to read the new top of stack.
// The next request is taken while a result still waits to be read.
module stack_bytecode_step_engine_unit #(
    parameter int PROGRAM_DEPTH = sbse_pkg::PROGRAM_DEPTH_DEF,
    parameter int STACK_DEPTH   = sbse_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sbse_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sbse_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    sbse_pkg::t_word prog_mem [PROGRAM_DEPTH];
    logic [31:0]     stack_mem [STACK_DEPTH];

    sbse_pkg::t_state r_state, n_state;
    logic [9:0]       r_entry;
    logic [10:0]      r_len;
    logic [31:0]      r_limit;
    logic [31:0]      r_pc, n_pc;
    logic [31:0]      r_steps, n_steps;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_top, n_top;
    logic [3:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    sbse_pkg::t_out   r_out, n_out;
    sbse_pkg::t_word  r_pm_q;
    logic [31:0]      r_stk_q;

    logic             in_accept;
    logic             out_load;
    logic             addr_ok;
    logic [31:0]      eff_len;
    logic             step_run;
    logic             go_exec;
    logic             pm_we;
    logic             st_we;
    logic [SAW-1:0]   st_wa;
    logic [31:0]      st_wd;
    logic             st_re;
    logic [SAW-1:0]   st_ra;
    logic             div_start;
    logic             div_done;
    logic [31:0]      div_q;
    logic [31:0]      bin_res;
    logic             has_two;

    assign in_accept  = i_in_valid && (r_state == sbse_pkg::S_IDLE);
    assign o_in_stall = (r_state != sbse_pkg::S_IDLE);
    assign out_load   = (r_state == sbse_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign addr_ok    = 32'(i_in.prog_address) < 32'(PROGRAM_DEPTH);
    assign eff_len    = (32'(r_len) > 32'(PROGRAM_DEPTH)) ? 32'(PROGRAM_DEPTH) : 32'(r_len);
    assign step_run   = (i_in.cmd == sbse_pkg::CMD_STEP) && (r_status == sbse_pkg::ST_RUN);
    assign go_exec    = step_run && (r_steps < r_limit) && (r_pc < eff_len);
    assign has_two    = (r_count >= CW'(2));

    always_comb begin
        case (r_pm_q.opcode)
            sbse_pkg::OP_ADD: bin_res = r_stk_q + r_top;
            sbse_pkg::OP_SUB: bin_res = r_stk_q - r_top;
            default:          bin_res = r_stk_q * r_top;
        endcase
    end

    sbse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_stk_q),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbse_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = (go_exec && in_accept) ? sbse_pkg::S_EXEC : sbse_pkg::S_DONE;
                end
            end
            sbse_pkg::S_EXEC: begin
                n_state = sbse_pkg::S_DONE;
                if (r_pm_q.opcode == sbse_pkg::OP_DIV && has_two) begin
                    if (r_top != 32'd0) begin
                        n_state = sbse_pkg::S_DIV;
                    end else if (r_count > CW'(2)) begin
                        n_state = sbse_pkg::S_RELOAD;
                    end
                end
            end
            sbse_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = sbse_pkg::S_DONE;
                end
            end
            sbse_pkg::S_RELOAD:  n_state = sbse_pkg::S_RELOAD2;
            sbse_pkg::S_RELOAD2: n_state = sbse_pkg::S_DONE;
            sbse_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = sbse_pkg::S_IDLE;
                end
            end
            default: n_state = sbse_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pc      = r_pc;
        n_steps   = r_steps;
        n_count   = r_count;
        n_top     = r_top;
        n_status  = r_status;
        pm_we     = 1'b0;
        st_we     = 1'b0;
        st_wa     = SAW'(r_count);
        st_wd     = r_top;
        st_re     = 1'b0;
        st_ra     = SAW'(r_count - CW'(2));
        div_start = 1'b0;
        n_out     = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            sbse_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (i_in.cmd)
                        sbse_pkg::CMD_WRITE: pm_we = addr_ok;
                        sbse_pkg::CMD_RESET: begin
                            n_count  = '0;
                            n_pc     = 32'(r_entry);
                            n_steps  = 32'd0;
                            n_status = sbse_pkg::ST_RUN;
                        end
                        sbse_pkg::CMD_STEP: begin
                            if (step_run) begin
                                if (r_steps >= r_limit) begin
                                    n_status = sbse_pkg::ST_LIMIT;
                                end else if (r_pc >= eff_len) begin
                                    n_status = sbse_pkg::ST_PCOUT;
                                end else begin
                                    st_re = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sbse_pkg::S_EXEC: begin
                n_steps = r_steps + 32'd1;
                n_pc    = r_pc + 32'd1;
                case (r_pm_q.opcode)
                    sbse_pkg::OP_NOP: ;
                    sbse_pkg::OP_PUSH_INT: begin
                        if (r_count == FULL) begin
                            n_status = sbse_pkg::ST_OVER;
                        end else begin
                            st_we   = 1'b1;
                            st_wd   = r_pm_q.immediate;
                            n_top   = r_pm_q.immediate;
                            n_count = r_count + CW'(1);
                        end
                    end
                    sbse_pkg::OP_POP: begin
                        if (r_count == '0) begin
                            n_status = sbse_pkg::ST_UNDER;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_top   = r_stk_q;
                        end
                    end
                    sbse_pkg::OP_DUP: begin
                        if (r_count == '0) begin
                            n_status = sbse_pkg::ST_UNDER;
                        end else if (r_count == FULL) begin
                            n_status = sbse_pkg::ST_OVER;
                        end else begin
                            st_we   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    sbse_pkg::OP_ADD, sbse_pkg::OP_SUB, sbse_pkg::OP_MUL: begin
                        if (!has_two) begin
                            n_status = sbse_pkg::ST_UNDER;
                            n_count  = '0;
                        end else begin
                            st_we   = 1'b1;
                            st_wa   = SAW'(r_count - CW'(2));
                            st_wd   = bin_res;
                            n_top   = bin_res;
                            n_count = r_count - CW'(1);
                        end
                    end
                    sbse_pkg::OP_DIV: begin
                        if (!has_two) begin
                            n_status = sbse_pkg::ST_UNDER;
                            n_count  = '0;
                        end else if (r_top == 32'd0) begin
                            n_status = sbse_pkg::ST_DIVZ;
                            n_count  = r_count - CW'(2);
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                    sbse_pkg::OP_JUMP: begin
                        if (r_pm_q.target >= eff_len) begin
                            n_status = sbse_pkg::ST_BADJ;
                        end else begin
                            n_pc = r_pm_q.target;
                        end
                    end
                    sbse_pkg::OP_JZ: begin
                        if (r_count == '0) begin
                            n_status = sbse_pkg::ST_UNDER;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_top   = r_stk_q;
                            if (r_top == 32'd0) begin
                                if (r_pm_q.target >= eff_len) begin
                                    n_status = sbse_pkg::ST_BADJ;
                                end else begin
                                    n_pc = r_pm_q.target;
                                end
                            end
                        end
                    end
                    sbse_pkg::OP_NATIVE: n_status = sbse_pkg::ST_NATIVE;
                    sbse_pkg::OP_HALT:   n_status = sbse_pkg::ST_HALT;
                    default:             n_status = sbse_pkg::ST_ILLEGAL;
                endcase
            end
            sbse_pkg::S_DIV: begin
                if (div_done) begin
                    st_we   = 1'b1;
                    st_wa   = SAW'(r_count - CW'(2));
                    st_wd   = div_q;
                    n_top   = div_q;
                    n_count = r_count - CW'(1);
                end
            end
            sbse_pkg::S_RELOAD: begin
                st_re = 1'b1;
                st_ra = SAW'(r_count - CW'(1));
            end
            sbse_pkg::S_RELOAD2: n_top = r_stk_q;
            sbse_pkg::S_DONE: begin
                if (out_load) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.pc_value    = r_pc;
                    n_out.top_value   = (r_count != '0) ? r_top : 32'd0;
                    n_out.stack_depth = 9'(r_count);
                    n_out.steps_done  = r_steps;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            prog_mem[PAW'(i_in.prog_address)] <= {i_in.opcode, i_in.immediate, i_in.jump_target};
        end
        if (in_accept) begin
            r_pm_q <= prog_mem[PAW'(r_pc)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stack_mem[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_stk_q <= stack_mem[st_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbse_pkg::S_IDLE;
            r_entry     <= sbse_pkg::ENTRY_POINT_RST;
            r_len       <= sbse_pkg::PROGRAM_LENGTH_RST;
            r_limit     <= sbse_pkg::STEP_LIMIT_RST;
            r_pc        <= 32'(sbse_pkg::ENTRY_POINT_RST);
            r_steps     <= 32'd0;
            r_count     <= '0;
            r_status    <= sbse_pkg::ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_steps     <= n_steps;
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbse_pkg::CFG_ENTRY_POINT:    r_entry <= i_cfg_data[9:0];
                    sbse_pkg::CFG_PROGRAM_LENGTH: r_len   <= i_cfg_data[10:0];
                    sbse_pkg::CFG_STEP_LIMIT:     r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_top <= n_top;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[bench/stack_bytecode_step_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// Stack bytecode step engine testbench
// Drives write, reset, step and unknown requests into the engine with random gaps on
// both handshakes, predicts every result with a behavioral copy of the stack
// machine and compares each result field by field in order.
// ----------------------------------------------------------------------------
module stack_bytecode_step_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PDEPTH = sbse_pkg::PROGRAM_DEPTH_DEF;
    localparam int SDEPTH = sbse_pkg::STACK_DEPTH_DEF;
    localparam logic [1:0] CMD_UNKNOWN    = 2'd3;
    localparam logic [7:0] OP_PUSH_REAL   = 8'h02;
    localparam logic [7:0] OP_PUSH_STRING = 8'h03;
    localparam logic [7:0] OP_UNDEFINED   = 8'hAB;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    sbse_pkg::t_in    i_in;
    logic             o_out_valid;
    logic             i_out_stall;
    sbse_pkg::t_out   o_out;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [31:0]      i_cfg_data;

    stack_bytecode_step_engine_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Machine state as predicted from the requests sent so far.
    logic [7:0]  prog_op  [PDEPTH];
    logic [31:0] prog_imm [PDEPTH];
    logic [31:0] prog_tgt [PDEPTH];
    bit          prog_written [PDEPTH];
    logic [31:0] stack_mem [SDEPTH];
    int unsigned stack_size;
    logic [31:0] pc_reg;
    logic [31:0] step_count;
    logic [3:0]  run_state;
    logic [9:0]  entry_reg;
    logic [10:0] length_reg;
    logic [31:0] limit_reg;

    sbse_pkg::t_out expected_results[$];
    int   in_idle_pct;
    int   out_idle_pct;
    int   mismatches;
    int   requests_sent;
    int   results_checked;
    int   halts_seen;
    int   faults_seen;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned active_length();
        return (int'(length_reg) > PDEPTH) ? PDEPTH : int'(length_reg);
    endfunction

    function automatic bit push_value(logic [31:0] v);
        if (stack_size >= SDEPTH) begin
            run_state = sbse_pkg::ST_OVER;
            return 1'b0;
        end
        stack_mem[stack_size] = v;
        stack_size++;
        return 1'b1;
    endfunction

    function automatic bit pop_value(output logic [31:0] v);
        v = '0;
        if (stack_size == 0) begin
            run_state = sbse_pkg::ST_UNDER;
            return 1'b0;
        end
        stack_size--;
        v = stack_mem[stack_size];
        return 1'b1;
    endfunction

    function automatic logic [31:0] divide_toward_zero(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic void execute_instruction(int unsigned len);
        logic [7:0]  op;
        logic [31:0] tgt;
        logic [31:0] rhs;
        logic [31:0] lhs;
        op  = prog_op[pc_reg];
        tgt = prog_tgt[pc_reg];
        step_count++;
        case (op)
            sbse_pkg::OP_NOP: ;
            sbse_pkg::OP_PUSH_INT: void'(push_value(prog_imm[pc_reg]));
            sbse_pkg::OP_POP: void'(pop_value(rhs));
            sbse_pkg::OP_DUP: begin
                if (stack_size == 0) run_state = sbse_pkg::ST_UNDER;
                else void'(push_value(stack_mem[stack_size - 1]));
            end
            sbse_pkg::OP_ADD, sbse_pkg::OP_SUB, sbse_pkg::OP_MUL, sbse_pkg::OP_DIV: begin
                if (pop_value(rhs) && pop_value(lhs)) begin
                    if (op == sbse_pkg::OP_ADD) void'(push_value(lhs + rhs));
                    else if (op == sbse_pkg::OP_SUB) void'(push_value(lhs - rhs));
                    else if (op == sbse_pkg::OP_MUL) void'(push_value(lhs * rhs));
                    else if (rhs == 0) run_state = sbse_pkg::ST_DIVZ;
                    else void'(push_value(divide_toward_zero(lhs, rhs)));
                end
            end
            sbse_pkg::OP_JUMP: ;
            sbse_pkg::OP_JZ: ;
            sbse_pkg::OP_NATIVE: run_state = sbse_pkg::ST_NATIVE;
            sbse_pkg::OP_HALT: run_state = sbse_pkg::ST_HALT;
            default: run_state = sbse_pkg::ST_ILLEGAL;
        endcase
        pc_reg++;
        if (op == sbse_pkg::OP_JUMP) begin
            if (tgt >= len) run_state = sbse_pkg::ST_BADJ;
            else pc_reg = tgt;
        end else if (op == sbse_pkg::OP_JZ) begin
            if (pop_value(lhs) && lhs == 0) begin
                if (tgt >= len) run_state = sbse_pkg::ST_BADJ;
                else pc_reg = tgt;
            end
        end
    endfunction

    function automatic sbse_pkg::t_out predict_result(sbse_pkg::t_in req);
        sbse_pkg::t_out res;
        if (req.cmd == sbse_pkg::CMD_WRITE) begin
            prog_op[req.prog_address]      = req.opcode;
            prog_imm[req.prog_address]     = req.immediate;
            prog_tgt[req.prog_address]     = req.jump_target;
            prog_written[req.prog_address] = 1'b1;
        end else if (req.cmd == sbse_pkg::CMD_RESET) begin
            stack_size = 0;
            pc_reg     = 32'(entry_reg);
            step_count = '0;
            run_state  = sbse_pkg::ST_RUN;
        end else if (req.cmd == sbse_pkg::CMD_STEP && run_state == sbse_pkg::ST_RUN) begin
            if (step_count >= limit_reg) run_state = sbse_pkg::ST_LIMIT;
            else if (pc_reg >= active_length()) run_state = sbse_pkg::ST_PCOUT;
            else execute_instruction(active_length());
            if (run_state == sbse_pkg::ST_HALT) halts_seen++;
            else if (run_state != sbse_pkg::ST_RUN) faults_seen++;
        end
        res.status      = run_state;
        res.pc_value    = pc_reg;
        res.top_value   = stack_size ? stack_mem[stack_size - 1] : '0;
        res.stack_depth = stack_size[8:0];
        res.steps_done  = step_count;
        return res;
    endfunction

    function automatic sbse_pkg::t_in random_request();
        sbse_pkg::t_in r;
        r.cmd          = 2'($urandom());
        r.prog_address = 10'($urandom());
        r.opcode       = 8'($urandom());
        r.immediate    = $urandom();
        r.jump_target  = $urandom();
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        sbse_pkg::t_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: %p", o_out);
                mismatches++;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (o_out.status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, o_out.status);
                    mismatches++;
                end
                if (o_out.pc_value !== exp_res.pc_value) begin
                    $error("pc_value: expected %0d, actual %0d",
                           exp_res.pc_value, o_out.pc_value);
                    mismatches++;
                end
                if (o_out.top_value !== exp_res.top_value) begin
                    $error("top_value: expected %0d, actual %0d",
                           exp_res.top_value, o_out.top_value);
                    mismatches++;
                end
                if (o_out.stack_depth !== exp_res.stack_depth) begin
                    $error("stack_depth: expected %0d, actual %0d",
                           exp_res.stack_depth, o_out.stack_depth);
                    mismatches++;
                end
                if (o_out.steps_done !== exp_res.steps_done) begin
                    $error("steps_done: expected %0d, actual %0d",
                           exp_res.steps_done, o_out.steps_done);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_request(input sbse_pkg::t_in req);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in       <= random_request();
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        expected_results.insert(expected_results.size(), predict_result(req));
        requests_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == sbse_pkg::CFG_ENTRY_POINT) entry_reg = value[9:0];
        else if (idx == sbse_pkg::CFG_PROGRAM_LENGTH) length_reg = value[10:0];
        else if (idx == sbse_pkg::CFG_STEP_LIMIT) limit_reg = value;
    endtask

    task automatic write_word(input logic [9:0] addr, input sbse_pkg::t_word w);
        sbse_pkg::t_in req;
        req.cmd          = sbse_pkg::CMD_WRITE;
        req.prog_address = addr;
        req.opcode       = w.opcode;
        req.immediate    = w.immediate;
        req.jump_target  = w.target;
        send_request(req);
    endtask

    task automatic send_command(input logic [1:0] cmd);
        sbse_pkg::t_in req;
        req = random_request();
        req.cmd = cmd;
        send_request(req);
    endtask

    function automatic sbse_pkg::t_word random_word();
        sbse_pkg::t_word w;
        logic [7:0] common_ops [13] = '{sbse_pkg::OP_PUSH_INT, sbse_pkg::OP_PUSH_INT,
            sbse_pkg::OP_PUSH_INT, sbse_pkg::OP_PUSH_INT, sbse_pkg::OP_DUP, sbse_pkg::OP_POP,
            sbse_pkg::OP_ADD, sbse_pkg::OP_SUB, sbse_pkg::OP_MUL, sbse_pkg::OP_DIV,
            sbse_pkg::OP_JUMP, sbse_pkg::OP_JZ, sbse_pkg::OP_NOP};
        int pick;
        pick = $urandom_range(99);
        if (pick < 90) w.opcode = common_ops[$urandom_range(12)];
        else if (pick < 94) w.opcode = sbse_pkg::OP_HALT;
        else if (pick < 96) w.opcode = sbse_pkg::OP_NATIVE;
        else w.opcode = 8'($urandom());
        w.immediate = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom();
        if ($urandom_range(9) == 0 || active_length() == 0) w.target = $urandom();
        else w.target = $urandom_range(active_length() - 1);
        return w;
    endfunction

    // A step never reaches a program word that was not loaded: load one first.
    task automatic step_once();
        if (run_state == sbse_pkg::ST_RUN && step_count < limit_reg
                && pc_reg < active_length() && !prog_written[pc_reg[9:0]])
            write_word(pc_reg[9:0], random_word());
        send_command(sbse_pkg::CMD_STEP);
    endtask

    task automatic load_and_run(input sbse_pkg::t_word prog[$], input int n_steps);
        foreach (prog[i]) write_word(10'(i), prog[i]);
        send_command(sbse_pkg::CMD_RESET);
        repeat (n_steps) step_once();
    endtask

    task automatic test_arithmetic_program();
        sbse_pkg::t_word prog[$];
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd16);
        write_register(sbse_pkg::CFG_ENTRY_POINT, 32'd0);
        write_register(sbse_pkg::CFG_STEP_LIMIT, 32'hFFFF_FFFF);
        prog = {
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'h8000_0000, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            sbse_pkg::t_word'{sbse_pkg::OP_DIV, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'h7FFF_FFFF, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_SUB, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'hFFFF_FFF9, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_MUL, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_DUP, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_ADD, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_JZ, 32'h0, 32'd12},
            sbse_pkg::t_word'{sbse_pkg::OP_NATIVE, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'hFFFF_FFF2, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd15},
            sbse_pkg::t_word'{sbse_pkg::OP_NOP, 32'h0, 32'h0},
            sbse_pkg::t_word'{sbse_pkg::OP_HALT, 32'h0, 32'h0}
        };
        load_and_run(prog, 16);
        send_command(CMD_UNKNOWN);
        write_word(10'd14, sbse_pkg::t_word'{sbse_pkg::OP_POP, 32'h0, 32'h0});
        write_word(10'd1, sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'hFFFF_FFF5, 32'd0});
        write_word(10'd2, sbse_pkg::t_word'{sbse_pkg::OP_DIV, 32'h0, 32'h0});
        send_command(sbse_pkg::CMD_RESET);
        repeat (6) step_once();
    endtask

    task automatic test_fault_cases();
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_POP, 32'h0, 32'h0}}, 2);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_DUP, 32'h0, 32'h0}}, 2);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd4, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_ADD, 32'h0, 32'h0}}, 3);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd5, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd6, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd0, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_DIV, 32'h0, 32'h0}}, 5);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'hFFFF_FFFF}}, 2);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd16}}, 1);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd0, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_JZ, 32'h0, 32'd16}}, 3);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd3, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_JZ, 32'h0, 32'd40},
                      sbse_pkg::t_word'{sbse_pkg::OP_JZ, 32'h0, 32'd0}}, 4);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_NATIVE, 32'h0, 32'h0}}, 2);
        load_and_run({sbse_pkg::t_word'{OP_PUSH_REAL, 32'h0, 32'h0}}, 1);
        load_and_run({sbse_pkg::t_word'{OP_PUSH_STRING, 32'h0, 32'h0}}, 1);
        load_and_run({sbse_pkg::t_word'{OP_UNDEFINED, 32'h0, 32'h0}}, 1);
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd2);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_NOP, 32'h0, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_NOP, 32'h0, 32'h0}}, 4);
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd0);
        send_command(sbse_pkg::CMD_RESET);
        repeat (2) step_once();
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd2047);
        write_register(sbse_pkg::CFG_ENTRY_POINT, 32'd1023);
        write_word(10'd1023, sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd1024});
        send_command(sbse_pkg::CMD_RESET);
        repeat (2) step_once();
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd1024);
        write_word(10'd1023, sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'h0, 32'h0});
        send_command(sbse_pkg::CMD_RESET);
        repeat (2) step_once();
    endtask

    task automatic test_stack_capacity();
        write_register(sbse_pkg::CFG_ENTRY_POINT, 32'd0);
        write_register(sbse_pkg::CFG_PROGRAM_LENGTH, 32'd4);
        write_word(10'd0, sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'h1234_5678, 32'h0});
        write_word(10'd1, sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd0});
        send_command(sbse_pkg::CMD_RESET);
        while (run_state == sbse_pkg::ST_RUN) step_once();
        step_once();
        write_word(10'd1, sbse_pkg::t_word'{sbse_pkg::OP_DUP, 32'h0, 32'h0});
        write_word(10'd2, sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd1});
        send_command(sbse_pkg::CMD_RESET);
        while (run_state == sbse_pkg::ST_RUN) step_once();
    endtask

    task automatic test_step_limit();
        write_register(sbse_pkg::CFG_STEP_LIMIT, 32'd1);
        load_and_run({sbse_pkg::t_word'{sbse_pkg::OP_PUSH_INT, 32'd9, 32'h0},
                      sbse_pkg::t_word'{sbse_pkg::OP_NOP, 32'h0, 32'h0}}, 3);
        write_register(sbse_pkg::CFG_STEP_LIMIT, 32'd5);
        write_word(10'd1, sbse_pkg::t_word'{sbse_pkg::OP_JUMP, 32'h0, 32'd0});
        send_command(sbse_pkg::CMD_RESET);
        repeat (7) step_once();
        write_register(sbse_pkg::CFG_STEP_LIMIT, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_programs(input int n_requests);
        int start;
        int n_load;
        int n_steps;
        int extra;
        start = requests_sent;
        while (requests_sent - start < n_requests) begin
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(9) < 7)
                    write_register(sbse_pkg::CFG_PROGRAM_LENGTH, $urandom_range(4, 24));
                else
                    write_register(sbse_pkg::CFG_PROGRAM_LENGTH, $urandom_range(25, 1024));
                if ($urandom_range(9) == 0)
                    write_register(sbse_pkg::CFG_ENTRY_POINT, $urandom_range(1023));
                else
                    write_register(sbse_pkg::CFG_ENTRY_POINT,
                                   $urandom_range(active_length() - 1));
                if ($urandom_range(4) == 0)
                    write_register(sbse_pkg::CFG_STEP_LIMIT, $urandom_range(1, 30));
                else
                    write_register(sbse_pkg::CFG_STEP_LIMIT,
                                   ($urandom_range(1) ? 32'hFFFF_FFFF : $urandom()));
            end
            n_load = (active_length() > 24) ? 24 : active_length();
            for (int a = 0; a < n_load; a++) write_word(10'(a), random_word());
            if ($urandom_range(3) == 0) write_word(10'($urandom()), random_word());
            send_command(sbse_pkg::CMD_RESET);
            n_steps = $urandom_range(5, 40);
            extra   = $urandom_range(2);
            for (int s = 0; s < n_steps; s++) begin
                if (run_state != sbse_pkg::ST_RUN) begin
                    if (extra == 0) break;
                    extra--;
                end
                step_once();
                if ($urandom_range(19) == 0) send_command(CMD_UNKNOWN);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = sbse_pkg::CFG_ENTRY_POINT;
        i_cfg_data   = '0;
        in_idle_pct  = 14;
        out_idle_pct = 58;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        halts_seen      = 0;
        faults_seen     = 0;
        foreach (prog_written[i]) prog_written[i] = 1'b0;
        stack_size = 0;
        pc_reg     = 32'(sbse_pkg::ENTRY_POINT_RST);
        step_count = '0;
        run_state  = sbse_pkg::ST_RUN;
        entry_reg  = sbse_pkg::ENTRY_POINT_RST;
        length_reg = sbse_pkg::PROGRAM_LENGTH_RST;
        limit_reg  = sbse_pkg::STEP_LIMIT_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_arithmetic_program();
        test_fault_cases();
        test_stack_capacity();
        test_step_limit();
        test_random_programs(150);
        in_idle_pct  = 58;
        out_idle_pct = 14;
        test_random_programs(150);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_programs(150);
        wait_idle();

        $display("Checked %0d results from %0d requests; %0d halts and %0d faults reached.",
                 results_checked, requests_sent, halts_seen, faults_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[stack_bytecode_step_engine_unit.f]
hw/rtl/sbse_pkg.sv
hw/rtl/sbse_div.sv
hw/rtl/stack_bytecode_step_engine_unit.sv
bench/stack_bytecode_step_engine_unit_test.sv
